### hdl/rvmod_pkg.sv
// shared types and constants of the retro vm opcode decoder
package rvmod_pkg;

	// field widths
	localparam int WORD_W   = 16;
	localparam int OPID_W   = 6;
	localparam int NIB_W    = 4;
	localparam int NNN_W    = 12;
	localparam int KK_W     = 8;
	localparam int VAR_W    = 2;
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 56;

	// machine variants
	typedef enum logic [VAR_W-1:0] {
		VAR_CLASSIC  = 2'd0,
		VAR_TWO_PAGE = 2'd1,
		VAR_EXTENDED = 2'd2,
		VAR_FURTHER  = 2'd3
	} variant_t;

	typedef logic [OPID_W-1:0] op_id_t;

	// operation identifiers
	localparam op_id_t OP_INVALID     = 6'd0;
	localparam op_id_t OP_CLS         = 6'd1;
	localparam op_id_t OP_RET         = 6'd2;
	localparam op_id_t OP_JP          = 6'd3;
	localparam op_id_t OP_CALL        = 6'd4;
	localparam op_id_t OP_SE_IMM      = 6'd5;
	localparam op_id_t OP_SNE_IMM     = 6'd6;
	localparam op_id_t OP_SE_REG      = 6'd7;
	localparam op_id_t OP_LD_IMM      = 6'd8;
	localparam op_id_t OP_ADD_IMM     = 6'd9;
	localparam op_id_t OP_LD_REG      = 6'd10;
	localparam op_id_t OP_OR          = 6'd11;
	localparam op_id_t OP_AND         = 6'd12;
	localparam op_id_t OP_XOR         = 6'd13;
	localparam op_id_t OP_ADD_REG     = 6'd14;
	localparam op_id_t OP_SUB         = 6'd15;
	localparam op_id_t OP_SHR         = 6'd16;
	localparam op_id_t OP_SUBN        = 6'd17;
	localparam op_id_t OP_SHL         = 6'd18;
	localparam op_id_t OP_SNE_REG     = 6'd19;
	localparam op_id_t OP_LD_I        = 6'd20;
	localparam op_id_t OP_JP_V0       = 6'd21;
	localparam op_id_t OP_RND         = 6'd22;
	localparam op_id_t OP_DRW         = 6'd23;
	localparam op_id_t OP_SKP         = 6'd24;
	localparam op_id_t OP_SKNP        = 6'd25;
	localparam op_id_t OP_LD_DT_RD    = 6'd26;
	localparam op_id_t OP_LD_KEY      = 6'd27;
	localparam op_id_t OP_LD_DT_WR    = 6'd28;
	localparam op_id_t OP_LD_ST       = 6'd29;
	localparam op_id_t OP_ADD_I       = 6'd30;
	localparam op_id_t OP_LD_FONT     = 6'd31;
	localparam op_id_t OP_BCD         = 6'd32;
	localparam op_id_t OP_STORE       = 6'd33;
	localparam op_id_t OP_LOAD        = 6'd34;
	localparam op_id_t OP_SCD         = 6'd35;
	localparam op_id_t OP_SCR         = 6'd36;
	localparam op_id_t OP_SCL         = 6'd37;
	localparam op_id_t OP_EXIT        = 6'd38;
	localparam op_id_t OP_LORES       = 6'd39;
	localparam op_id_t OP_HIRES       = 6'd40;
	localparam op_id_t OP_DRW16       = 6'd41;
	localparam op_id_t OP_LD_BIGFONT  = 6'd42;
	localparam op_id_t OP_STORE_FLAGS = 6'd43;
	localparam op_id_t OP_LOAD_FLAGS  = 6'd44;
	localparam op_id_t OP_SCU         = 6'd45;
	localparam op_id_t OP_SAVE_RANGE  = 6'd46;
	localparam op_id_t OP_LOAD_RANGE  = 6'd47;
	localparam op_id_t OP_LD_I_LONG   = 6'd48;
	localparam op_id_t OP_PLANE       = 6'd49;
	localparam op_id_t OP_AUDIO       = 6'd50;

	// decoded item handed from the decode logic to the result register
	typedef struct packed {
		op_id_t             op_id;
		logic [NIB_W-1:0]   reg_x;
		logic [NIB_W-1:0]   reg_y;
		logic [NIB_W-1:0]   nibble_n;
		logic [NNN_W-1:0]   addr_nnn;
		logic [KK_W-1:0]    byte_kk;
		logic [WORD_W-1:0]  word_echo;
		logic               invalid;
	} dec_res_t;

endpackage

### hdl/rvmod_decode.sv
// combinational opcode decode with per-variant overrides
module rvmod_decode (
	input  logic [rvmod_pkg::WORD_W-1:0] word,
	input  rvmod_pkg::variant_t          variant,
	output rvmod_pkg::dec_res_t          res
);
	import rvmod_pkg::*;

	logic [3:0] top;
	logic [3:0] lo4;
	logic [7:0] kk;
	op_id_t     id_cls;
	op_id_t     id_ext;
	op_id_t     id_fur;
	op_id_t     id;

	assign top = word[15:12];
	assign lo4 = word[3:0];
	assign kk  = word[7:0];

	// classic opcode set
	always_comb begin
		id_cls = OP_INVALID;
		case (top)
			4'h0: begin
				if (word == 16'h00E0) id_cls = OP_CLS;
				else if (word == 16'h00EE) id_cls = OP_RET;
			end
			4'h1: id_cls = OP_JP;
			4'h2: id_cls = OP_CALL;
			4'h3: id_cls = OP_SE_IMM;
			4'h4: id_cls = OP_SNE_IMM;
			4'h5: if (lo4 == 4'h0) id_cls = OP_SE_REG;
			4'h6: id_cls = OP_LD_IMM;
			4'h7: id_cls = OP_ADD_IMM;
			4'h8: begin
				case (lo4)
					4'h0: id_cls = OP_LD_REG;
					4'h1: id_cls = OP_OR;
					4'h2: id_cls = OP_AND;
					4'h3: id_cls = OP_XOR;
					4'h4: id_cls = OP_ADD_REG;
					4'h5: id_cls = OP_SUB;
					4'h6: id_cls = OP_SHR;
					4'h7: id_cls = OP_SUBN;
					4'hE: id_cls = OP_SHL;
					default: id_cls = OP_INVALID;
				endcase
			end
			4'h9: if (lo4 == 4'h0) id_cls = OP_SNE_REG;
			4'hA: id_cls = OP_LD_I;
			4'hB: id_cls = OP_JP_V0;
			4'hC: id_cls = OP_RND;
			4'hD: id_cls = OP_DRW;
			4'hE: begin
				if (kk == 8'h9E) id_cls = OP_SKP;
				else if (kk == 8'hA1) id_cls = OP_SKNP;
			end
			default: begin
				case (kk)
					8'h07: id_cls = OP_LD_DT_RD;
					8'h0A: id_cls = OP_LD_KEY;
					8'h15: id_cls = OP_LD_DT_WR;
					8'h18: id_cls = OP_LD_ST;
					8'h1E: id_cls = OP_ADD_I;
					8'h29: id_cls = OP_LD_FONT;
					8'h33: id_cls = OP_BCD;
					8'h55: id_cls = OP_STORE;
					8'h65: id_cls = OP_LOAD;
					default: id_cls = OP_INVALID;
				endcase
			end
		endcase
	end

	// extended set overrides, zero when nothing matches
	always_comb begin
		id_ext = OP_INVALID;
		case (top)
			4'h0: begin
				if (word[15:4] == 12'h00C) id_ext = OP_SCD;
				else if (word == 16'h00FB) id_ext = OP_SCR;
				else if (word == 16'h00FC) id_ext = OP_SCL;
				else if (word == 16'h00FD) id_ext = OP_EXIT;
				else if (word == 16'h00FE) id_ext = OP_LORES;
				else if (word == 16'h00FF) id_ext = OP_HIRES;
			end
			4'hD: if (lo4 == 4'h0) id_ext = OP_DRW16;
			4'hF: begin
				if (kk == 8'h30) id_ext = OP_LD_BIGFONT;
				else if (kk == 8'h75) id_ext = OP_STORE_FLAGS;
				else if (kk == 8'h85) id_ext = OP_LOAD_FLAGS;
			end
			default: id_ext = OP_INVALID;
		endcase
	end

	// further extended set overrides, zero when nothing matches
	always_comb begin
		id_fur = OP_INVALID;
		case (top)
			4'h0: if (word[15:4] == 12'h00D) id_fur = OP_SCU;
			4'h5: begin
				if (lo4 == 4'h2) id_fur = OP_SAVE_RANGE;
				else if (lo4 == 4'h3) id_fur = OP_LOAD_RANGE;
			end
			4'hF: begin
				if (word == 16'hF000) id_fur = OP_LD_I_LONG;
				else if (kk == 8'h01) id_fur = OP_PLANE;
				else if (kk == 8'h02) id_fur = OP_AUDIO;
			end
			default: id_fur = OP_INVALID;
		endcase
	end

	// later overrides win
	always_comb begin
		id = id_cls;
		if (variant == VAR_TWO_PAGE && word == 16'h0230) id = OP_CLS;
		if ((variant == VAR_EXTENDED || variant == VAR_FURTHER) && id_ext != OP_INVALID)
			id = id_ext;
		if (variant == VAR_FURTHER && id_fur != OP_INVALID) id = id_fur;
	end

	// operand fields are always sliced from the word
	always_comb begin
		res.op_id     = id;
		res.reg_x     = word[11:8];
		res.reg_y     = word[7:4];
		res.nibble_n  = word[3:0];
		res.addr_nnn  = word[11:0];
		res.byte_kk   = word[7:0];
		res.word_echo = word;
		res.invalid   = (id == OP_INVALID);
	end

endmodule

### hdl/retro_vm_opcode_decoder_core.sv
// top level of the retro vm opcode decoder: input register, decode, result register
//
//  channel | direction | handshake              | payload
//  s       | in        | s_tvalid / s_tready    | s_tdata: instr_word
//  m       | out       | m_tvalid / m_tready    | m_tdata: operation and operands, m_tuser: invalid
//  cfg     | in        | cfg_valid / cfg_ready  | cfg_data: machine_variant
//
// one item per cycle sustained while m_tready is high; a taken item passes the input register,
// then the result register, before its result is on m
// arst_n clears the variant to classic and empties both stages
// a stalled output holds the result register; the input register still fills behind it
module retro_vm_opcode_decoder_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [rvmod_pkg::S_TDATA_W-1:0]      s_tdata,   // [15:0] instr_word
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [5:0] op_id, [9:6] reg_x, [13:10] reg_y, [17:14] nibble_n, [29:18] addr_nnn,
	// [37:30] byte_kk, [53:38] word_echo, [55:54] zero
	output logic [rvmod_pkg::M_TDATA_W-1:0]      m_tdata,
	output logic                                 m_tuser,   // [0] invalid
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [rvmod_pkg::VAR_W-1:0]          cfg_data   // [1:0] machine_variant
);
	import rvmod_pkg::*;

	variant_t              variant_q;
	logic                  valid_s1;
	logic [WORD_W-1:0]     word_s1;
	logic                  valid_s2;
	dec_res_t              res_s2;
	dec_res_t              dec_res;
	logic                  adv_s2;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q <= VAR_CLASSIC;
		end else if (cfg_valid) begin
			variant_q <= variant_t'(cfg_data);
		end
	end

	// stage handshake
	assign adv_s2   = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			word_s1 <= s_tdata;
		end
	end

	// decode
	rvmod_decode u_decode (
		.word    (word_s1),
		.variant (variant_q),
		.res     (dec_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			res_s2 <= dec_res;
		end
	end

	// output packing
	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, res_s2.word_echo, res_s2.byte_kk, res_s2.addr_nnn,
		res_s2.nibble_n, res_s2.reg_y, res_s2.reg_x, res_s2.op_id};
	assign m_tuser  = res_s2.invalid;

endmodule

### tb/sv/tb_retro_vm_opcode_decoder_core.sv
// testbench for the retro vm opcode decoder: directed and random stream traffic checked against a decode model
`timescale 1ns / 100ps

module tb_retro_vm_opcode_decoder_core;
	import rvmod_pkg::*;

	localparam int NUM_PATTERNS = 44;
	localparam int SEGMENTS     = 16;
	localparam int SEG_ITEMS    = 100;
	localparam int HOLD_CYCLES  = 300;

	// expected decode results in arrival order, with the decode model itself
	class decode_board;
		dec_res_t pending_q[$];
		variant_t variant;
		int       errors;

		function new();
			variant = VAR_CLASSIC;
			errors  = 0;
		endfunction

		function void set_variant(variant_t v);
			variant = v;
		endfunction

		function int pending();
			return pending_q.size();
		endfunction

		// operation id of one word under the current variant
		function op_id_t decode_op(logic [15:0] w);
			op_id_t     id;
			logic [3:0] top;
			logic [3:0] lo4;
			logic [7:0] kk;
			top = w[15:12];
			lo4 = w[3:0];
			kk  = w[7:0];
			id  = OP_INVALID;
			// base opcode set
			case (top)
				4'h0: begin
					if (w == 16'h00E0) id = OP_CLS;
					else if (w == 16'h00EE) id = OP_RET;
				end
				4'h1: id = OP_JP;
				4'h2: id = OP_CALL;
				4'h3: id = OP_SE_IMM;
				4'h4: id = OP_SNE_IMM;
				4'h5: if (lo4 == 4'h0) id = OP_SE_REG;
				4'h6: id = OP_LD_IMM;
				4'h7: id = OP_ADD_IMM;
				4'h8: begin
					if (lo4 <= 4'h7) id = op_id_t'(OP_LD_REG + lo4);
					else if (lo4 == 4'hE) id = OP_SHL;
				end
				4'h9: if (lo4 == 4'h0) id = OP_SNE_REG;
				4'hA: id = OP_LD_I;
				4'hB: id = OP_JP_V0;
				4'hC: id = OP_RND;
				4'hD: id = OP_DRW;
				4'hE: begin
					if (kk == 8'h9E) id = OP_SKP;
					else if (kk == 8'hA1) id = OP_SKNP;
				end
				default: begin
					case (kk)
						8'h07: id = OP_LD_DT_RD;
						8'h0A: id = OP_LD_KEY;
						8'h15: id = OP_LD_DT_WR;
						8'h18: id = OP_LD_ST;
						8'h1E: id = OP_ADD_I;
						8'h29: id = OP_LD_FONT;
						8'h33: id = OP_BCD;
						8'h55: id = OP_STORE;
						8'h65: id = OP_LOAD;
						default: id = OP_INVALID;
					endcase
				end
			endcase
			// two-page clear screen
			if (variant == VAR_TWO_PAGE && w == 16'h0230) id = OP_CLS;
			// extended superset, also under the further set
			if (variant == VAR_EXTENDED || variant == VAR_FURTHER) begin
				if (top == 4'h0) begin
					if (w[15:4] == 12'h00C) id = OP_SCD;
					else if (w == 16'h00FB) id = OP_SCR;
					else if (w == 16'h00FC) id = OP_SCL;
					else if (w == 16'h00FD) id = OP_EXIT;
					else if (w == 16'h00FE) id = OP_LORES;
					else if (w == 16'h00FF) id = OP_HIRES;
				end else if (top == 4'hD) begin
					if (lo4 == 4'h0) id = OP_DRW16;
				end else if (top == 4'hF) begin
					if (kk == 8'h30) id = OP_LD_BIGFONT;
					else if (kk == 8'h75) id = OP_STORE_FLAGS;
					else if (kk == 8'h85) id = OP_LOAD_FLAGS;
				end
			end
			// further extended superset wins last
			if (variant == VAR_FURTHER) begin
				if (top == 4'h0) begin
					if (w[15:4] == 12'h00D) id = OP_SCU;
				end else if (top == 4'h5) begin
					if (lo4 == 4'h2) id = OP_SAVE_RANGE;
					else if (lo4 == 4'h3) id = OP_LOAD_RANGE;
				end else if (top == 4'hF) begin
					if (w == 16'hF000) id = OP_LD_I_LONG;
					else if (kk == 8'h01) id = OP_PLANE;
					else if (kk == 8'h02) id = OP_AUDIO;
				end
			end
			return id;
		endfunction

		// an input item was taken: queue its decode
		function void note_word(logic [15:0] w);
			dec_res_t r;
			r.op_id     = decode_op(w);
			r.reg_x     = w[11:8];
			r.reg_y     = w[7:4];
			r.nibble_n  = w[3:0];
			r.addr_nnn  = w[11:0];
			r.byte_kk   = w[7:0];
			r.word_echo = w;
			r.invalid   = (r.op_id == OP_INVALID);
			pending_q.push_back(r);
		endfunction

		function void check_field(string name, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
				errors++;
			end
		endfunction

		// a result item left the block: compare with the oldest decode
		function void check_result(logic [M_TDATA_W-1:0] data, logic flag);
			dec_res_t r;
			if (pending_q.size() == 0) begin
				$display("%0t: result with none pending, expected nothing, actual %h / %b",
					$time, data, flag);
				errors++;
				return;
			end
			r = pending_q.pop_front();
			check_field("op_id", 16'(r.op_id), 16'(data[5:0]));
			check_field("reg_x", 16'(r.reg_x), 16'(data[9:6]));
			check_field("reg_y", 16'(r.reg_y), 16'(data[13:10]));
			check_field("nibble_n", 16'(r.nibble_n), 16'(data[17:14]));
			check_field("addr_nnn", 16'(r.addr_nnn), 16'(data[29:18]));
			check_field("byte_kk", 16'(r.byte_kk), 16'(data[37:30]));
			check_field("word_echo", r.word_echo, data[53:38]);
			check_field("pad", 16'h0000, 16'(data[55:54]));
			check_field("invalid", 16'(r.invalid), 16'(flag));
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tuser;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [VAR_W-1:0]     cfg_data = '0;

	decode_board words;
	int src_idle_pct = 17;
	int dst_idle_pct = 60;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int hold_left = 0;

	retro_vm_opcode_decoder_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// result side: check taken items, drive ready with random stalls and one long hold-off
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) words.check_result(m_tdata, m_tuser);
		if (hold_req && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= dst_idle_pct);
		end
	end

	// opcode templates as {fixed-bit mask, value}; other bits are random
	function automatic logic [31:0] op_pattern(int idx);
		case (idx)
			0:  return {16'hFFFF, 16'h00E0};
			1:  return {16'hFFFF, 16'h00EE};
			2:  return {16'hFFFF, 16'h0230};
			3:  return {16'hF000, 16'h1000};
			4:  return {16'hF000, 16'h2000};
			5:  return {16'hF000, 16'h3000};
			6:  return {16'hF000, 16'h4000};
			7:  return {16'hF00F, 16'h5000};
			8:  return {16'hF000, 16'h6000};
			9:  return {16'hF000, 16'h7000};
			10: return {16'hF000, 16'h8000};
			11: return {16'hF00F, 16'h800E};
			12: return {16'hF00F, 16'h9000};
			13: return {16'hF000, 16'hA000};
			14: return {16'hF000, 16'hB000};
			15: return {16'hF000, 16'hC000};
			16: return {16'hF000, 16'hD000};
			17: return {16'hF00F, 16'hD000};
			18: return {16'hF0FF, 16'hE09E};
			19: return {16'hF0FF, 16'hE0A1};
			20: return {16'hF0FF, 16'hF007};
			21: return {16'hF0FF, 16'hF00A};
			22: return {16'hF0FF, 16'hF015};
			23: return {16'hF0FF, 16'hF018};
			24: return {16'hF0FF, 16'hF01E};
			25: return {16'hF0FF, 16'hF029};
			26: return {16'hF0FF, 16'hF033};
			27: return {16'hF0FF, 16'hF055};
			28: return {16'hF0FF, 16'hF065};
			29: return {16'hFFF0, 16'h00C0};
			30: return {16'hFFFF, 16'h00FB};
			31: return {16'hFFFF, 16'h00FC};
			32: return {16'hFFFF, 16'h00FD};
			33: return {16'hFFFF, 16'h00FE};
			34: return {16'hFFFF, 16'h00FF};
			35: return {16'hF0FF, 16'hF030};
			36: return {16'hF0FF, 16'hF075};
			37: return {16'hF0FF, 16'hF085};
			38: return {16'hFFF0, 16'h00D0};
			39: return {16'hF00F, 16'h5002};
			40: return {16'hF00F, 16'h5003};
			41: return {16'hFFFF, 16'hF000};
			42: return {16'hF0FF, 16'hF001};
			default: return {16'hF0FF, 16'hF002};
		endcase
	endfunction

	// mostly well-formed opcodes with random operands, the rest raw noise
	function automatic logic [15:0] random_word();
		logic [31:0] pm;
		logic [15:0] r;
		r = 16'($urandom);
		if ($urandom_range(99) < 25) return r;
		pm = op_pattern($urandom_range(NUM_PATTERNS - 1));
		return (pm[15:0] & pm[31:16]) | (r & ~pm[31:16]);
	endfunction

	// offer one item, with random gaps ahead of it
	task automatic send_word(input logic [15:0] w);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= w;
		do @(posedge clk); while (!s_tready);
		words.note_word(w);
	endtask

	// stop offering and wait until every pending result is out
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (words.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_variant(input variant_t v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		words.set_variant(v);
	endtask

	initial begin
		static logic [15:0] further_words [18] = '{
			16'h0000, 16'hFFFF, 16'h00E0, 16'h00EE, 16'h00C0, 16'h00CF,
			16'h00DF, 16'h00FB, 16'h00FC, 16'h00FD, 16'h00FE, 16'h00FF,
			16'hDFF0, 16'h5AB2, 16'h5AB3, 16'hF000, 16'hF101, 16'hFE02
		};
		words = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset variant is classic: extended forms must not decode
		send_word(16'h0230);
		send_word(16'hD120);
		send_word(16'h00C3);
		send_word(16'hF000);
		drain_results();
		// two-page clear screen
		write_variant(VAR_TWO_PAGE);
		send_word(16'h0230);
		send_word(16'h00E0);
		send_word(16'h00FF);
		drain_results();
		// further set: overrides and extremes
		write_variant(VAR_FURTHER);
		foreach (further_words[i]) send_word(further_words[i]);

		// random segments, each under its own variant
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			if (seg == 6) begin
				src_idle_pct = 60;
				dst_idle_pct = 17;
			end
			if (seg == 12) begin
				src_idle_pct = 0;
				dst_idle_pct = 0;
			end
			drain_results();
			if (seg < 8) write_variant(variant_t'(seg % 4));
			else write_variant(variant_t'($urandom_range(3)));
			// long receiver hold-off while the sender keeps pushing
			if (seg == 13) hold_req <= 1'b1;
			for (int i = 0; i < SEG_ITEMS; i++) send_word(random_word());
		end

		drain_results();
		if (words.errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

### files.f
hdl/rvmod_pkg.sv
hdl/rvmod_decode.sv
hdl/retro_vm_opcode_decoder_core.sv
tb/sv/tb_retro_vm_opcode_decoder_core.sv
